/* rtl/core/spq_pkg.sv */
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 5;

    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_EXTRACT = 2'd1;
    localparam logic [1:0] MODE_MODIFY  = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    localparam logic [1:0] OP_HOLD    = 2'd0;
    localparam logic [1:0] OP_INSERT  = 2'd1;
    localparam logic [1:0] OP_EXTRACT = 2'd2;
    localparam logic [1:0] OP_REMOVE  = 2'd3;

    localparam logic signed [DATA_W-1:0] MINUS_ONE = -32'sd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] pri;
    } entry_t;

    typedef struct packed {
        logic [1:0] op;
        entry_t     key;
    } cell_ctrl_t;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] item_value;
        logic signed [DATA_W-1:0] item_priority;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] taken_value;
        logic [1:0]               status;
        logic signed [DATA_W-1:0] head_value;
        logic signed [DATA_W-1:0] head_priority;
        logic                     is_empty_flag;
        logic [OCC_W-1:0]         occupancy;
    } result_t;

endpackage

/* rtl/core/spq_cell.sv */
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       valid,
    input  entry_t     left,
    input  entry_t     right,
    input  logic       left_keep,
    output logic       keep,
    input  logic       seen_in,
    output logic       seen_out,
    output entry_t     entry,
    output entry_t     entry_next
);

    entry_t entry_reg;
    logic   match;

    assign keep     = valid && !(entry_reg.pri < ctrl.key.pri);
    assign match    = valid && (entry_reg.val == ctrl.key.val);
    assign seen_out = seen_in || match;
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (!keep)
                begin
                    entry_next = left_keep ? ctrl.key : left;
                end
            end
            OP_EXTRACT:
            begin
                entry_next = right;
            end
            OP_REMOVE:
            begin
                if (seen_out)
                begin
                    entry_next = right;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* rtl/core/sorted_priority_queue_unit.sv */
// Sorted priority queue, highest priority at the front, equal priorities leave in
// arrival order. Entries live in a row of cells that shift toward or away from
// the front.
// Command channel: an item (mode, item_value, item_priority) is taken at a rising
// edge where start is high and busy is low.
// Result channel: done is high for one cycle with result valid; the receiver
// cannot stall, so each result is taken in that cycle.
// Insert and extract: the result is registered and appears in the cycle after the
// item is taken; a new item may be issued every cycle while busy is low.
// Priority change with a match: a remove pass through the cell row, then an
// insert pass; busy is high during the insert pass and the result follows it.
// Otherwise the change gives its result like insert and extract.
// The first-match search ripples combinationally through the cells.
// Reset empties the queue (count to zero) and clears done and busy; entry
// contents are not cleared.
module sorted_priority_queue_unit
    import spq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pend_reg;
    entry_t           pend_entry_reg;
    logic             done_reg;
    result_t          result_reg;
    result_t          result_next;

    cell_ctrl_t       ctrl;
    logic             accept;
    logic             found;
    logic             res_load;
    logic             is_full;
    logic             no_entries;

    entry_t           cur   [0:CAPACITY-1];
    entry_t           nxt   [0:CAPACITY-1];
    logic             keeps [0:CAPACITY];
    logic             seens [0:CAPACITY];

    assign accept     = start && !busy;
    assign busy       = pend_reg;
    assign done       = done_reg;
    assign result     = result_reg;
    assign is_full    = (count_reg == CNT_W'(CAPACITY));
    assign no_entries = (count_reg == '0);
    assign keeps[0]   = 1'b1;
    assign seens[0]   = 1'b0;
    assign found      = seens[CAPACITY];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            if (gi == 0)
            begin : g_first
                assign left_e = ctrl.key;
            end
            else
            begin : g_mid
                assign left_e = cur[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = cur[gi+1];
            end
            spq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .valid      (count_reg > CNT_W'(gi)),
                .left       (left_e),
                .right      (right_e),
                .left_keep  (keeps[gi]),
                .keep       (keeps[gi+1]),
                .seen_in    (seens[gi]),
                .seen_out   (seens[gi+1]),
                .entry      (cur[gi]),
                .entry_next (nxt[gi])
            );
        end
    endgenerate

    // cell command
    always_comb
    begin
        ctrl.op      = OP_HOLD;
        ctrl.key.val = cmd.item_value;
        ctrl.key.pri = cmd.item_priority;
        if (pend_reg)
        begin
            ctrl.op  = OP_INSERT;
            ctrl.key = pend_entry_reg;
        end
        else if (accept)
        begin
            case (cmd.mode)
                MODE_INSERT:
                begin
                    if (!is_full)
                    begin
                        ctrl.op = OP_INSERT;
                    end
                end
                MODE_EXTRACT:
                begin
                    if (!no_entries)
                    begin
                        ctrl.op = OP_EXTRACT;
                    end
                end
                MODE_MODIFY:
                begin
                    ctrl.op = OP_REMOVE;
                end
                default:
                begin
                    ctrl.op = OP_HOLD;
                end
            endcase
        end
    end

    // next count
    always_comb
    begin
        count_next = count_reg;
        if (pend_reg)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (accept)
        begin
            case (cmd.mode)
                MODE_INSERT:
                begin
                    if (!is_full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_EXTRACT:
                begin
                    if (!no_entries)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                MODE_MODIFY:
                begin
                    if (found)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // result; head and occupancy are built from the state after the operation
    always_comb
    begin
        res_load                  = pend_reg || (accept && !(cmd.mode == MODE_MODIFY && found));
        result_next.taken_value   = '0;
        result_next.status        = STATUS_OK;
        if (!pend_reg)
        begin
            case (cmd.mode)
                MODE_INSERT:
                begin
                    if (is_full)
                    begin
                        result_next.status = STATUS_FULL;
                    end
                end
                MODE_EXTRACT:
                begin
                    if (no_entries)
                    begin
                        result_next.taken_value = MINUS_ONE;
                        result_next.status      = STATUS_EMPTY;
                    end
                    else
                    begin
                        result_next.taken_value = cur[0].val;
                    end
                end
                MODE_MODIFY:
                begin
                    if (no_entries)
                    begin
                        result_next.status = STATUS_EMPTY;
                    end
                    else if (!found)
                    begin
                        result_next.status = STATUS_NOT_FOUND;
                    end
                end
                default:
                begin
                    result_next.status = STATUS_OK;
                end
            endcase
        end
        if (count_next == '0)
        begin
            result_next.head_value    = MINUS_ONE;
            result_next.head_priority = MINUS_ONE;
            result_next.is_empty_flag = 1'b1;
        end
        else
        begin
            result_next.head_value    = nxt[0].val;
            result_next.head_priority = nxt[0].pri;
            result_next.is_empty_flag = 1'b0;
        end
        result_next.occupancy = OCC_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= accept && (cmd.mode == MODE_MODIFY) && found;
            done_reg  <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_entry_reg.val <= cmd.item_value;
            pend_entry_reg.pri <= cmd.item_priority;
        end
        if (res_load)
        begin
            result_reg <= result_next;
        end
    end

    a_pend_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> !pend_reg)
        else $error("reinsert pass lasted more than one cycle");

    a_pend_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> done_reg)
        else $error("reinsert pass gave no result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_extract_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.mode == MODE_EXTRACT && !no_entries)
        |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("extract did not lower the count");

    a_found_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        found |-> !no_entries)
        else $error("match found in an empty queue");

endmodule
